FILE: src/gpic_pkg.sv
// Package for the gait phase impedance controller: types, register indexes and reset values.
`timescale 1ns / 1ps

package gpic_pkg;

    localparam int unsigned ANGLE_W  = 16;
    localparam int unsigned LOAD_W   = 12;
    localparam int unsigned GAIN_W   = 48;
    localparam int unsigned TORQUE_W = 24;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned NUM_PHASES = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef enum logic [PHASE_W-1:0] {
        PH_STANCE_FLEX = 2'd0,
        PH_STANCE_EXT  = 2'd1,
        PH_SWING_FLEX  = 2'd2,
        PH_SWING_EXT   = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOAD_LIMIT      = 3'd0,
        REG_MAX_FLEXION     = 3'd1,
        REG_EXT_VEL_LIMIT   = 3'd2,
        REG_GAINS_ST_FLEX   = 3'd3,
        REG_GAINS_ST_EXT    = 3'd4,
        REG_GAINS_SW_FLEX   = 3'd5,
        REG_GAINS_SW_EXT    = 3'd6,
        REG_UNUSED          = 3'd7
    } t_cfg_idx;

    localparam logic [LOAD_W-1:0]         RST_LOAD_LIMIT     = 12'd50;
    localparam logic signed [ANGLE_W-1:0] RST_MAX_FLEXION    = 16'sd4096;
    localparam logic signed [ANGLE_W-1:0] RST_EXT_VEL_LIMIT  = 16'sd410;
    localparam logic [GAIN_W-1:0]         RST_GAINS_ST_FLEX  = 48'd43980491981619;
    localparam logic [GAIN_W-1:0]         RST_GAINS_ST_EXT   = 48'd52776611807232;
    localparam logic [GAIN_W-1:0]         RST_GAINS_SW_FLEX  = 48'd8796106461594;
    localparam logic [GAIN_W-1:0]         RST_GAINS_SW_EXT   = 48'd14074634698752;

    localparam logic signed [TORQUE_W-1:0] TORQUE_MAX = 24'sh7FFFFF;
    localparam logic signed [TORQUE_W-1:0] TORQUE_MIN = 24'sh800000;

    typedef struct packed {
        logic [LOAD_W-1:0]         load_limit;
        logic signed [ANGLE_W-1:0] flex_angle_limit;
        logic signed [ANGLE_W-1:0] extension_velocity_limit;
    } t_thresholds;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] knee_angle;
        logic signed [ANGLE_W-1:0] knee_velocity;
        logic [LOAD_W-1:0]         load_force;
    } t_sample;

endpackage

FILE: src/gpic_in_if.sv
// Input channel: one sensor sample per transaction.
`timescale 1ns / 1ps

interface gpic_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   knee_angle;
    logic signed [15:0]   knee_velocity;
    logic [11:0]          load_force;

    modport source (output valid, knee_angle, knee_velocity, load_force, input ready);
    modport sink   (input valid, knee_angle, knee_velocity, load_force, output ready);
endinterface

FILE: src/gpic_out_if.sv
// Output channel: one torque command and gait phase per transaction.
`timescale 1ns / 1ps

interface gpic_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   torque_command;
    logic [1:0]           gait_phase;

    modport source (output valid, torque_command, gait_phase, input ready);
    modport sink   (input valid, torque_command, gait_phase, output ready);
endinterface

FILE: src/gpic_cfg_regs.sv
// Configuration register file: thresholds and per-phase packed gains.
`timescale 1ns / 1ps

module gpic_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gpic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gpic_pkg::GAIN_W-1:0]         i_cfg_data,
    output gpic_pkg::t_thresholds               o_thr,
    output logic [gpic_pkg::GAIN_W-1:0]         o_gains [gpic_pkg::NUM_PHASES]
);
    import gpic_pkg::*;

    t_thresholds       r_thr;
    logic [GAIN_W-1:0] r_gains [NUM_PHASES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.load_limit               <= RST_LOAD_LIMIT;
            r_thr.flex_angle_limit         <= RST_MAX_FLEXION;
            r_thr.extension_velocity_limit <= RST_EXT_VEL_LIMIT;
            r_gains[0] <= RST_GAINS_ST_FLEX;
            r_gains[1] <= RST_GAINS_ST_EXT;
            r_gains[2] <= RST_GAINS_SW_FLEX;
            r_gains[3] <= RST_GAINS_SW_EXT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LOAD_LIMIT:     r_thr.load_limit <= i_cfg_data[LOAD_W-1:0];
                REG_MAX_FLEXION:    r_thr.flex_angle_limit <= i_cfg_data[ANGLE_W-1:0];
                REG_EXT_VEL_LIMIT:  r_thr.extension_velocity_limit <= i_cfg_data[ANGLE_W-1:0];
                REG_GAINS_ST_FLEX:  r_gains[0] <= i_cfg_data;
                REG_GAINS_ST_EXT:   r_gains[1] <= i_cfg_data;
                REG_GAINS_SW_FLEX:  r_gains[2] <= i_cfg_data;
                REG_GAINS_SW_EXT:   r_gains[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_thr   = r_thr;
    assign o_gains = r_gains;

endmodule

FILE: src/gpic_phase_fsm.sv
// Four-phase gait state machine, advanced once per sample.
`timescale 1ns / 1ps

module gpic_phase_fsm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  gpic_pkg::t_sample       i_sample,
    input  gpic_pkg::t_thresholds   i_thr,
    output gpic_pkg::t_phase        o_phase_nxt,
    output gpic_pkg::t_phase        o_phase
);
    import gpic_pkg::*;

    t_phase r_phase;
    t_phase n_phase;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_STANCE_FLEX:
                if (i_sample.knee_velocity < i_thr.extension_velocity_limit)
                    n_phase = PH_STANCE_EXT;
            PH_STANCE_EXT:
                if (i_sample.load_force < i_thr.load_limit)
                    n_phase = PH_SWING_FLEX;
            PH_SWING_FLEX:
                if (i_sample.knee_angle >= i_thr.flex_angle_limit)
                    n_phase = PH_SWING_EXT;
            PH_SWING_EXT:
                if (i_sample.load_force >= i_thr.load_limit)
                    n_phase = PH_STANCE_FLEX;
            default: n_phase = PH_STANCE_FLEX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STANCE_FLEX;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase_nxt = n_phase;
    assign o_phase     = r_phase;

endmodule

FILE: src/gpic_torque.sv
// Impedance law: torque = k*(eq_angle - angle) - b*velocity, rounded to Q12.12 and clamped.
`timescale 1ns / 1ps

module gpic_torque (
    input  logic [gpic_pkg::GAIN_W-1:0]           i_gains,
    input  gpic_pkg::t_sample                     i_sample,
    output logic signed [gpic_pkg::TORQUE_W-1:0]  o_torque
);
    import gpic_pkg::*;

    localparam int unsigned DIFF_W = ANGLE_W + 1;
    localparam int unsigned P1_W   = ANGLE_W + DIFF_W;
    localparam int unsigned P2_W   = 2 * ANGLE_W;
    localparam int unsigned SUM_W  = P1_W + 2;

    logic signed [ANGLE_W-1:0] w_k;
    logic signed [ANGLE_W-1:0] w_b;
    logic signed [ANGLE_W-1:0] w_teq;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [P1_W-1:0]    w_p1;
    logic signed [P2_W-1:0]    w_p2;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_shr;

    assign w_k   = i_gains[47:32];
    assign w_b   = i_gains[31:16];
    assign w_teq = i_gains[15:0];

    assign w_diff = DIFF_W'(w_teq) - DIFF_W'(i_sample.knee_angle);
    assign w_p1   = P1_W'(w_k) * P1_W'(w_diff);
    assign w_p2   = P2_W'(w_b) * P2_W'(i_sample.knee_velocity);
    // round half up: add half an LSB, then floor through the arithmetic shift
    assign w_sum  = SUM_W'(w_p1) - SUM_W'(w_p2) + SUM_W'(2048);
    assign w_shr  = w_sum >>> 12;

    always_comb begin
        if (w_shr > SUM_W'(TORQUE_MAX)) begin
            o_torque = TORQUE_MAX;
        end else if (w_shr < SUM_W'(TORQUE_MIN)) begin
            o_torque = TORQUE_MIN;
        end else begin
            o_torque = w_shr[TORQUE_W-1:0];
        end
    end

endmodule

FILE: src/gait_phase_impedance_controller_top.sv
// Top level of the gait phase impedance controller.
`timescale 1ns / 1ps

// Each sensor sample (knee angle, velocity, load) is registered on acceptance; once the output
// register is free or draining, it advances the four-phase gait machine and the torque
// k*(eq_angle-angle)-b*velocity is formed with the new phase's gains and captured in the output
// register. Throughput is one sample per cycle while the output is not stalled, set by the
// single pass through the phase logic and the 16x17 and 16x16 multipliers. Input ready stays
// high while the output register is free or being drained, so a stalled result only holds back
// the pipeline once both stages are full. Configuration writes take effect at once and are
// meant to be made while no sample is in flight.
module gait_phase_impedance_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gpic_in_if.sink                         i_in,
    gpic_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [gpic_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gpic_pkg::GAIN_W-1:0]     i_cfg_data
);
    import gpic_pkg::*;

    t_thresholds                w_thr;
    logic [GAIN_W-1:0]          w_gains [NUM_PHASES];
    t_phase                     w_phase_nxt;
    t_phase                     w_phase;
    logic signed [TORQUE_W-1:0] w_torque;
    logic                       w_adv;
    logic                       w_in_acc;

    logic                       r_s1_vld;
    t_sample                    r_s1;
    logic                       r_out_vld;
    logic signed [TORQUE_W-1:0] r_out_torque;
    logic [PHASE_W-1:0]         r_out_phase;

    // move the sample stage into the output register when it is free or draining
    assign w_adv    = r_s1_vld && (!r_out_vld || o_out.ready);
    assign w_in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_vld || w_adv;

    gpic_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (w_thr),
        .o_gains    (w_gains)
    );

    gpic_phase_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_sample    (r_s1),
        .i_thr       (w_thr),
        .o_phase_nxt (w_phase_nxt),
        .o_phase     (w_phase)
    );

    gpic_torque u_torque (
        .i_gains  (w_gains[w_phase_nxt]),
        .i_sample (r_s1),
        .o_torque (w_torque)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1.knee_angle    <= i_in.knee_angle;
            r_s1.knee_velocity <= i_in.knee_velocity;
            r_s1.load_force    <= i_in.load_force;
        end
        if (w_adv) begin
            r_out_torque <= w_torque;
            r_out_phase  <= w_phase_nxt;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.torque_command = r_out_torque;
    assign o_out.gait_phase     = r_out_phase;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_adv |=> r_s1_vld)
        else $error("sample stage dropped a stalled sample");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld && r_out_phase == w_phase)
        else $error("advanced sample missing from output register");

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (w_phase == $past(w_phase)) || (w_phase == t_phase'($past(w_phase) + 2'd1)))
        else $error("gait phase skipped a step");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_phase))
        else $error("gait phase moved without a sample");
`endif

endmodule
